FILE: hdl/evs_pkg.sv
// Shared types and constants for the eight-value sorter.
// Depends on nothing; used by the cell module and the top level.
package evs_pkg;

    // Width of one value in the set.
    localparam int DATA_W = 32;

    // Phase of the sorter: collecting samples or emitting the sorted run.
    typedef enum logic
    {
        ST_LOAD,
        ST_EMIT
    } state_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed
    {
        logic insert;   // place the broadcast sample in sorted position
        logic shift;    // move every value one cell toward the output
    } cell_ctrl_t;

endpackage

FILE: hdl/evs_cell.sv
// One cell of the sorting chain: holds one value and its valid bit.
// Depends on evs_pkg for the data width and the command struct.
module evs_cell
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  evs_pkg::cell_ctrl_t               ctrl,
    input  logic signed [evs_pkg::DATA_W-1:0] sample,
    input  logic                              prev_valid,
    input  logic signed [evs_pkg::DATA_W-1:0] prev_value,
    input  logic                              next_valid,
    input  logic signed [evs_pkg::DATA_W-1:0] next_value,
    output logic                              valid,
    output logic signed [evs_pkg::DATA_W-1:0] value
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [evs_pkg::DATA_W-1:0] value_reg;
    logic signed [evs_pkg::DATA_W-1:0] value_next;
    logic                              fits_here;
    logic                              prev_larger;

    // The sample lands here when the lower neighbor is filled and this cell is empty
    // or larger; an empty cell above an empty neighbor stays empty.
    // The lower neighbor must move up when it already holds a larger value.
    assign fits_here   = prev_valid && (!valid_reg || (sample < value_reg));
    assign prev_larger = prev_valid && (prev_value > sample);

    // Next value: insert the sample, take the lower neighbor's value, or shift out.
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.shift)
        begin
            valid_next = next_valid;
            value_next = next_value;
        end
        else if (ctrl.insert)
        begin
            if (prev_larger)
            begin
                valid_next = 1'b1;
                value_next = prev_value;
            end
            else if (fits_here)
            begin
                valid_next = 1'b1;
                value_next = sample;
            end
        end
    end

    // Valid bit is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stored value needs no reset.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;

endmodule

FILE: hdl/evs_out_stage.sv
// Output register of the sorter: holds one result request until it is taken.
// Depends on evs_pkg for the data width.
module evs_out_stage
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic signed [evs_pkg::DATA_W-1:0] load_value,
    input  logic                              load_final,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic signed [evs_pkg::DATA_W-1:0] sorted_value,
    output logic                              final_flag,
    output logic                              free
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [evs_pkg::DATA_W-1:0] value_reg;
    logic                              final_reg;

    // The register can take a new result when empty or when its request leaves now.
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload is only written when a new result is loaded.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= load_value;
            final_reg <= load_final;
        end
    end

    assign out_valid    = valid_reg;
    assign sorted_value = value_reg;
    assign final_flag   = final_reg;

endmodule

FILE: hdl/eight_value_sorter.sv
// Top level of the eight-value sorter: a chain of insertion cells and an output register.
// Depends on evs_pkg, evs_cell and evs_out_stage.
//
// Usage:
//   The input channel (in_valid, in_ready, sample) takes SET_SIZE signed values,
//   one request per cycle. Each sample is broadcast to a row of SET_SIZE cells
//   that keep the values in ascending order; a cell either keeps its value,
//   takes the sample, or takes the value of its lower neighbor.
//   Once the set is full, in_ready drops and the chain shifts toward the output
//   channel (out_valid, out_ready, sorted_value, final_flag), smallest value
//   first; final_flag marks the largest value. Equal values are all kept.
//   After the last sample is accepted, the phase register switches to emitting; the
//   first result is then loaded into the output register once it is free. Loading and
//   emitting never overlap, so no sample of the next set is taken before the chain
//   has shifted out; it drains one value per cycle while the output register is free.
//   When the receiver stalls, the result stays in the output register and the
//   chain holds still. Loading of the next set starts while the last result
//   of the previous set still waits.
//   Reset empties every cell, clears the output register and returns to loading.
module eight_value_sorter
#(
    parameter int SET_SIZE = 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [evs_pkg::DATA_W-1:0] sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [evs_pkg::DATA_W-1:0] sorted_value,
    output logic                              final_flag
);

    localparam int CNT_W = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SET_SIZE - 1);

    evs_pkg::state_t                   state_reg;
    evs_pkg::state_t                   state_next;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [CNT_W-1:0]                  cnt_next;
    evs_pkg::cell_ctrl_t               ctrl;
    logic                              out_free;
    logic                              in_take;
    logic                              cell_valid [SET_SIZE];
    logic signed [evs_pkg::DATA_W-1:0] cell_value [SET_SIZE];

    assign in_ready = (state_reg == evs_pkg::ST_LOAD);
    assign in_take  = in_valid && in_ready;

    // Commands to the chain.
    always_comb
    begin
        ctrl.insert = in_take;
        ctrl.shift  = (state_reg == evs_pkg::ST_EMIT) && out_free;
    end

    // Phase control and the shared load / emit counter.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            evs_pkg::ST_LOAD:
            begin
                if (in_take)
                begin
                    if (cnt_reg == LAST_IDX)
                    begin
                        cnt_next   = '0;
                        state_next = evs_pkg::ST_EMIT;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            evs_pkg::ST_EMIT:
            begin
                if (ctrl.shift)
                begin
                    if (cnt_reg == LAST_IDX)
                    begin
                        cnt_next   = '0;
                        state_next = evs_pkg::ST_LOAD;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = evs_pkg::ST_LOAD;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= evs_pkg::ST_LOAD;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Chain of cells, cell 0 holds the smallest value and feeds the output.
    genvar i;
    generate
        for (i = 0; i < SET_SIZE; i++)
        begin : g_cell
            logic                              prev_valid;
            logic signed [evs_pkg::DATA_W-1:0] prev_value;
            logic                              next_valid;
            logic signed [evs_pkg::DATA_W-1:0] next_value;

            // Cell 0 sees a filled floor holding the most negative value.
            if (i == 0)
            begin : g_first
                assign prev_valid = 1'b1;
                assign prev_value = {1'b1, {(evs_pkg::DATA_W-1){1'b0}}};
            end
            else
            begin : g_mid_lo
                assign prev_valid = cell_valid[i-1];
                assign prev_value = cell_value[i-1];
            end

            if (i == SET_SIZE - 1)
            begin : g_last
                assign next_valid = 1'b0;
                assign next_value = '0;
            end
            else
            begin : g_mid_hi
                assign next_valid = cell_valid[i+1];
                assign next_value = cell_value[i+1];
            end

            evs_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .sample     (sample),
                .prev_valid (prev_valid),
                .prev_value (prev_value),
                .next_valid (next_valid),
                .next_value (next_value),
                .valid      (cell_valid[i]),
                .value      (cell_value[i])
            );
        end
    endgenerate

    // Output register.
    evs_out_stage u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (ctrl.shift),
        .load_value   (cell_value[0]),
        .load_final   (cnt_reg == LAST_IDX),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .sorted_value (sorted_value),
        .final_flag   (final_flag),
        .free         (out_free)
    );

endmodule

FILE: hdl/evs_checker.sv
// Port-level checks for the eight-value sorter, attached by bind.
// Depends on the top level's ports only.
module evs_checker
#(
    parameter int SET_SIZE = 8
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] sorted_value,
    input logic               final_flag
);

    localparam int RUN_W = $clog2(SET_SIZE) + 1;

    logic [RUN_W-1:0]   run_cnt_reg;
    logic signed [31:0] last_reg;
    logic               out_take;
    logic               in_take;

    assign out_take = out_valid && out_ready;
    assign in_take  = in_valid && in_ready;

    // Results taken so far in the current sorted run.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cnt_reg <= '0;
        end
        else if (out_take)
        begin
            run_cnt_reg <= final_flag ? '0 : run_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            last_reg <= sorted_value;
        end
    end

    // A stalled result request holds its payload.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sorted_value) && $stable(final_flag))
        else $error("result changed while stalled");

    // The final mark sits exactly on the last value of each run.
    a_final_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> (final_flag == (run_cnt_reg == RUN_W'(SET_SIZE - 1))))
        else $error("final_flag misplaced in sorted run");

    // Values within a run come out in ascending order.
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && (run_cnt_reg != '0) |-> (sorted_value >= last_reg))
        else $error("sorted run not ascending");

    // No sample is taken in a cycle in which a result other than the last of its run is taken.
    a_no_load_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && !final_flag |-> !in_take)
        else $error("sample accepted during emission");

endmodule

bind eight_value_sorter evs_checker #(.SET_SIZE(SET_SIZE)) u_evs_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .final_flag   (final_flag)
);
